### design/trbo_pkg.sv
// ----------------------------------------------------------------------------
// trbo_pkg
// Shared types and constants for the trace ring buffer with overwrite.
// ----------------------------------------------------------------------------
package trbo_pkg;

  localparam int PID_W    = 22;
  localparam int MAJOR_W  = 12;
  localparam int MINOR_W  = 20;
  localparam int INODE_W  = 64;
  localparam int OFFSET_W = 63;
  localparam int PROBE_W  = 2;
  localparam int COUNT_W  = 6;
  localparam int OVR_W    = 32;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [PROBE_W-1:0] PROBE_NONE   = 2'd0;
  localparam logic [PROBE_W-1:0] PROBE_MULTI  = 2'd1;
  localparam logic [PROBE_W-1:0] PROBE_SINGLE = 2'd2;

  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [MAJOR_W-1:0]  major;
    logic [MINOR_W-1:0]  minor;
    logic [INODE_W-1:0]  inode;
    logic [OFFSET_W-1:0] offset;
    logic                single;
  } entry_t;

  typedef struct packed {
    logic write_event;
    logic start_read;
    logic emit_entry;
    logic emit_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic remaining_zero;
    logic remaining_one;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

endpackage

### design/trbo_ctrl.sv
// ----------------------------------------------------------------------------
// trbo_ctrl
// Controller: takes input transactions and sequences the entries of a read.
// ----------------------------------------------------------------------------
module trbo_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  trbo_pkg::dp_status_t  status,
  output trbo_pkg::ctrl_cmd_t   cmd
);
  import trbo_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (kind == KIND_READ) begin
            cmd.start_read = 1'b1;
            state_next     = ST_READ;
          end else begin
            cmd.write_event = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (status.out_free) begin
          if (status.remaining_zero) begin
            cmd.emit_empty = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            cmd.emit_entry = 1'b1;
            if (status.remaining_one) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/trbo_dp.sv
// ----------------------------------------------------------------------------
// trbo_dp
// Datapath: entry memory, ring pointers, overrun counter and output register.
// ----------------------------------------------------------------------------
module trbo_dp #(
  parameter int RING_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  trbo_pkg::ctrl_cmd_t               cmd,
  output trbo_pkg::dp_status_t              status,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic [trbo_pkg::PID_W-1:0]        pid,
  input  logic [trbo_pkg::MAJOR_W-1:0]      major_num,
  input  logic [trbo_pkg::MINOR_W-1:0]      dev_minor,
  input  logic [trbo_pkg::INODE_W-1:0]      inode_number,
  input  logic [trbo_pkg::OFFSET_W-1:0]     file_offset,
  input  logic [trbo_pkg::PROBE_W-1:0]      probe_id,
  input  logic [trbo_pkg::COUNT_W-1:0]      read_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              entry_valid,
  output logic                              last_entry,
  output logic [trbo_pkg::PID_W-1:0]        out_pid,
  output logic [trbo_pkg::MAJOR_W-1:0]      out_major,
  output logic [trbo_pkg::MINOR_W-1:0]      out_minor,
  output logic [trbo_pkg::INODE_W-1:0]      out_inode,
  output logic [trbo_pkg::OFFSET_W-1:0]     out_offset,
  output logic [trbo_pkg::PROBE_W-1:0]      out_probe,
  output logic [trbo_pkg::OVR_W-1:0]        overrun_total
);
  import trbo_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);

  entry_t          mem [RING_DEPTH];
  entry_t          rdata;
  entry_t          wentry;
  logic [PW-1:0]   read_pointer;
  logic [PW-1:0]   write_pointer;
  logic [PW-1:0]   write_pointer_next;
  logic [PW-1:0]   remaining;
  logic [PW:0]     diff;
  logic [PW-1:0]   held;
  logic [COUNT_W-1:0] held_ext;
  logic [COUNT_W-1:0] grant;
  logic [OVR_W-1:0]   overrun_counter;
  logic            logging_enable;
  logic            do_store;
  logic            emit;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    advance = (p == LAST_SLOT) ? '0 : p + PW'(1);
  endfunction

  assign do_store = cmd.write_event && logging_enable && (major_num != '0);
  assign emit     = cmd.emit_entry || cmd.emit_empty;
  assign write_pointer_next = advance(write_pointer);

  assign wentry.pid    = pid;
  assign wentry.major  = major_num;
  assign wentry.minor  = dev_minor;
  assign wentry.inode  = inode_number;
  assign wentry.offset = file_offset;
  assign wentry.single = (probe_id == PROBE_SINGLE);

  // held entries, modulo the ring size
  assign diff     = {1'b0, write_pointer} - {1'b0, read_pointer};
  assign held     = diff[PW] ? PW'(diff + (PW+1)'(RING_DEPTH)) : diff[PW-1:0];
  assign held_ext = COUNT_W'(held);
  assign grant    = (read_count < held_ext) ? read_count : held_ext;

  assign status.out_free       = !out_valid || out_ready;
  assign status.remaining_zero = (remaining == '0);
  assign status.remaining_one  = (remaining == PW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      logging_enable <= 1'b0;
    end else if (cfg_we) begin
      logging_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer    <= '0;
      write_pointer   <= '0;
      overrun_counter <= '0;
    end else if (do_store) begin
      write_pointer <= write_pointer_next;
      if (write_pointer_next == read_pointer) begin
        read_pointer    <= advance(read_pointer);
        overrun_counter <= overrun_counter + OVR_W'(1);
      end
    end else if (cmd.emit_entry) begin
      read_pointer <= advance(read_pointer);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      remaining <= PW'(grant);
    end else if (cmd.emit_entry) begin
      remaining <= remaining - PW'(1);
    end
  end

  // entry memory, read data doubles as the output payload register
  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[write_pointer] <= wentry;
    end
    if (cmd.emit_empty) begin
      rdata <= '0;
    end else if (cmd.emit_entry) begin
      rdata <= mem[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      entry_valid   <= cmd.emit_entry;
      last_entry    <= cmd.emit_empty || status.remaining_one;
      overrun_total <= overrun_counter;
    end
  end

  assign out_pid    = rdata.pid;
  assign out_major  = rdata.major;
  assign out_minor  = rdata.minor;
  assign out_inode  = rdata.inode;
  assign out_offset = rdata.offset;
  assign out_probe  = !entry_valid ? PROBE_NONE :
                      (rdata.single ? PROBE_SINGLE : PROBE_MULTI);

endmodule

### design/trace_ring_buffer_overwrite.sv
// ----------------------------------------------------------------------------
// trace_ring_buffer_overwrite
// Trace capture ring buffer that drops the oldest entry when full.
//
//   channel   direction  handshake             payload
//   in        input      in_valid/in_ready     kind, pid, major_num, dev_minor,
//                                              inode_number, file_offset,
//                                              probe_id, read_count
//   out       output     out_valid/out_ready   entry_valid, last_entry, out_*,
//                                              overrun_total
//   cfg       input      cfg_we                cfg_wdata (logging enable)
//
// Events are accepted back to back. A read request is accepted, then its
// granted entries are emitted in turn, limited by the single memory read
// port; an empty read emits one empty result in their place.
// Output stalls hold the read sequence; no input is taken during a read.
// Reset clears the pointers, the overrun counter and logging enable; the
// entry memory needs no clearing pass.
// ----------------------------------------------------------------------------
module trace_ring_buffer_overwrite #(
  parameter int RING_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [trbo_pkg::PID_W-1:0]        pid,
  input  logic [trbo_pkg::MAJOR_W-1:0]      major_num,
  input  logic [trbo_pkg::MINOR_W-1:0]      dev_minor,
  input  logic [trbo_pkg::INODE_W-1:0]      inode_number,
  input  logic [trbo_pkg::OFFSET_W-1:0]     file_offset,
  input  logic [trbo_pkg::PROBE_W-1:0]      probe_id,
  input  logic [trbo_pkg::COUNT_W-1:0]      read_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              entry_valid,
  output logic                              last_entry,
  output logic [trbo_pkg::PID_W-1:0]        out_pid,
  output logic [trbo_pkg::MAJOR_W-1:0]      out_major,
  output logic [trbo_pkg::MINOR_W-1:0]      out_minor,
  output logic [trbo_pkg::INODE_W-1:0]      out_inode,
  output logic [trbo_pkg::OFFSET_W-1:0]     out_offset,
  output logic [trbo_pkg::PROBE_W-1:0]      out_probe,
  output logic [trbo_pkg::OVR_W-1:0]        overrun_total
);
  import trbo_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  trbo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  trbo_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pid           (pid),
    .major_num     (major_num),
    .dev_minor     (dev_minor),
    .inode_number  (inode_number),
    .file_offset   (file_offset),
    .probe_id      (probe_id),
    .read_count    (read_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .entry_valid   (entry_valid),
    .last_entry    (last_entry),
    .out_pid       (out_pid),
    .out_major     (out_major),
    .out_minor     (out_minor),
    .out_inode     (out_inode),
    .out_offset    (out_offset),
    .out_probe     (out_probe),
    .overrun_total (overrun_total)
  );

`ifndef ASSERT_OFF
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_entry || cmd.emit_empty) |-> status.out_free)
    else $error("result loaded while output register is occupied");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.write_event, cmd.start_read, cmd.emit_entry, cmd.emit_empty}))
    else $error("more than one datapath command at once");

  a_read_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_READ) |=> !in_ready)
    else $error("input taken while a read is in progress");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_empty |=> (out_valid && !entry_valid && last_entry))
    else $error("empty read result malformed");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trace ring buffer with overwrite of the oldest
// entry. A ring model in the bench predicts every read result from the
// accepted events and read requests. The checker compares each output
// transaction field by field against the oldest prediction. Stimulus runs
// directed cases first: filtering, empty reads, field extremes, odd probe
// ids, clipped requests and ring overflow. A long output stall follows,
// then random traffic under several logging settings with random idling
// on both channels, and a final back-to-back run with no idling.
// ----------------------------------------------------------------------------
module tb_top;
  import trbo_pkg::*;

  localparam int DEPTH         = 64;
  localparam int IDLE_PCT      = 38;
  localparam int MAX_CYCLES    = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic                kind;
    logic [PID_W-1:0]    pid;
    logic [MAJOR_W-1:0]  major;
    logic [MINOR_W-1:0]  minor;
    logic [INODE_W-1:0]  inode;
    logic [OFFSET_W-1:0] offset;
    logic [PROBE_W-1:0]  probe;
    logic [COUNT_W-1:0]  count;
  } trace_item_t;

  typedef struct packed {
    logic                has_entry;
    logic                last;
    logic [PID_W-1:0]    pid;
    logic [MAJOR_W-1:0]  major;
    logic [MINOR_W-1:0]  minor;
    logic [INODE_W-1:0]  inode;
    logic [OFFSET_W-1:0] offset;
    logic [PROBE_W-1:0]  probe;
    logic [OVR_W-1:0]    overrun;
  } capture_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_we       = 1'b0;
  logic                cfg_wdata    = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                kind         = 1'b0;
  logic [PID_W-1:0]    pid          = '0;
  logic [MAJOR_W-1:0]  major_num    = '0;
  logic [MINOR_W-1:0]  dev_minor    = '0;
  logic [INODE_W-1:0]  inode_number = '0;
  logic [OFFSET_W-1:0] file_offset  = '0;
  logic [PROBE_W-1:0]  probe_id     = '0;
  logic [COUNT_W-1:0]  read_count   = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                entry_valid;
  logic                last_entry;
  logic [PID_W-1:0]    out_pid;
  logic [MAJOR_W-1:0]  out_major;
  logic [MINOR_W-1:0]  out_minor;
  logic [INODE_W-1:0]  out_inode;
  logic [OFFSET_W-1:0] out_offset;
  logic [PROBE_W-1:0]  out_probe;
  logic [OVR_W-1:0]    overrun_total;

  // ring model state
  entry_t           ring_entries [DEPTH];
  int unsigned      ring_head     = 0;
  int unsigned      ring_tail     = 0;
  logic [OVR_W-1:0] dropped_total = '0;
  logic             logging_on    = 1'b0;
  capture_t         pending_entries [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;
  int unsigned hold_len    = 0;
  int unsigned hold_seq    = 0;
  int unsigned seen_seq    = 0;
  int unsigned hold_left   = 0;

  trace_ring_buffer_overwrite #(.RING_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .pid          (pid),
    .major_num    (major_num),
    .dev_minor    (dev_minor),
    .inode_number (inode_number),
    .file_offset  (file_offset),
    .probe_id     (probe_id),
    .read_count   (read_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .entry_valid  (entry_valid),
    .last_entry   (last_entry),
    .out_pid      (out_pid),
    .out_major    (out_major),
    .out_minor    (out_minor),
    .out_inode    (out_inode),
    .out_offset   (out_offset),
    .out_probe    (out_probe),
    .overrun_total(overrun_total)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output side: random back-pressure plus the long hold
  always @(negedge clk) begin
    if (hold_seq != seen_seq) begin
      seen_seq  = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic void apply_to_ring(trace_item_t it);
    int unsigned held;
    int unsigned grant;
    int unsigned i;
    capture_t    c;
    if (it.kind == KIND_EVENT) begin
      if (!logging_on || it.major == '0) return;
      ring_entries[ring_tail] = '{pid: it.pid, major: it.major, minor: it.minor,
                                  inode: it.inode, offset: it.offset,
                                  single: (it.probe == PROBE_SINGLE)};
      ring_tail = (ring_tail + 1) % DEPTH;
      if (ring_tail == ring_head) begin
        ring_head     = (ring_head + 1) % DEPTH;
        dropped_total = dropped_total + 1'b1;
      end
      return;
    end
    held  = (ring_tail + DEPTH - ring_head) % DEPTH;
    grant = (it.count < held) ? it.count : held;
    if (grant == 0) begin
      c         = '0;
      c.last    = 1'b1;
      c.overrun = dropped_total;
      pending_entries.push_back(c);
      return;
    end
    for (i = 0; i < grant; i++) begin
      c.has_entry = 1'b1;
      c.last      = (i + 1 == grant);
      c.pid       = ring_entries[ring_head].pid;
      c.major     = ring_entries[ring_head].major;
      c.minor     = ring_entries[ring_head].minor;
      c.inode     = ring_entries[ring_head].inode;
      c.offset    = ring_entries[ring_head].offset;
      c.probe     = ring_entries[ring_head].single ? PROBE_SINGLE : PROBE_MULTI;
      c.overrun   = dropped_total;
      pending_entries.push_back(c);
      ring_head = (ring_head + 1) % DEPTH;
    end
  endfunction

  task automatic report_mismatch(bit unexpected, capture_t e, capture_t g);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected)
        $display("cycle %0d: unexpected transaction", cycle_count);
      else
        $display("cycle %0d: mismatch, exp valid=%b last=%b pid=%h maj=%h min=%h",
                 cycle_count, e.has_entry, e.last, e.pid, e.major, e.minor);
      if (!unexpected)
        $display("  exp inode=%h off=%h probe=%0d ovr=%0d",
                 e.inode, e.offset, e.probe, e.overrun);
      $display("  got valid=%b last=%b pid=%h maj=%h min=%h",
               g.has_entry, g.last, g.pid, g.major, g.minor);
      $display("  got inode=%h off=%h probe=%0d ovr=%0d",
               g.inode, g.offset, g.probe, g.overrun);
    end
  endtask

  always @(posedge clk) begin
    capture_t got;
    capture_t exp_entry;
    if (!rst && out_valid && out_ready) begin
      got = '{has_entry: entry_valid, last: last_entry, pid: out_pid,
              major: out_major, minor: out_minor, inode: out_inode,
              offset: out_offset, probe: out_probe, overrun: overrun_total};
      if (pending_entries.size() == 0) begin
        report_mismatch(1'b1, '0, got);
      end else begin
        exp_entry = pending_entries.pop_front();
        if (got.has_entry != exp_entry.has_entry || got.last != exp_entry.last ||
            got.pid != exp_entry.pid || got.major != exp_entry.major ||
            got.minor != exp_entry.minor || got.inode != exp_entry.inode ||
            got.offset != exp_entry.offset || got.probe != exp_entry.probe ||
            got.overrun != exp_entry.overrun)
          report_mismatch(1'b0, exp_entry, got);
      end
    end
  end

  task automatic send_item(trace_item_t it);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= it.kind;
    pid          <= it.pid;
    major_num    <= it.major;
    dev_minor    <= it.minor;
    inode_number <= it.inode;
    file_offset  <= it.offset;
    probe_id     <= it.probe;
    read_count   <= it.count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_to_ring(it);
  endtask

  task automatic wait_ring_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_logging(logic en);
    wait_ring_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_we    <= 1'b0;
    logging_on = en;
  endtask

  function automatic trace_item_t event_item(logic [PID_W-1:0] p, logic [MAJOR_W-1:0] maj,
                                             logic [MINOR_W-1:0] mn, logic [INODE_W-1:0] ino,
                                             logic [OFFSET_W-1:0] off,
                                             logic [PROBE_W-1:0] prb);
    trace_item_t it;
    it        = '0;
    it.kind   = KIND_EVENT;
    it.pid    = p;
    it.major  = maj;
    it.minor  = mn;
    it.inode  = ino;
    it.offset = off;
    it.probe  = prb;
    return it;
  endfunction

  function automatic trace_item_t read_item(logic [COUNT_W-1:0] n);
    trace_item_t it;
    it       = '0;
    it.kind  = KIND_READ;
    it.count = n;
    return it;
  endfunction

  function automatic trace_item_t random_item();
    trace_item_t it;
    int unsigned r;
    it.kind   = ($urandom_range(0, 99) < 72) ? KIND_EVENT : KIND_READ;
    it.pid    = PID_W'($urandom);
    it.major  = ($urandom_range(0, 9) == 0) ? '0 : MAJOR_W'($urandom);
    it.minor  = MINOR_W'($urandom);
    it.inode  = {$urandom, $urandom};
    it.offset = OFFSET_W'({$urandom, $urandom});
    it.probe  = PROBE_W'(($urandom_range(0, 9) < 2) ? $urandom_range(0, 3) :
                                                      $urandom_range(1, 2));
    r = $urandom_range(0, 99);
    if (r < 10)
      it.count = '0;
    else if (r < 80)
      it.count = COUNT_W'($urandom_range(1, 8));
    else
      it.count = COUNT_W'($urandom_range(9, 63));
    return it;
  endfunction

  function automatic trace_item_t random_event();
    trace_item_t it;
    it      = random_item();
    it.kind = KIND_EVENT;
    if (it.major == '0) it.major = MAJOR_W'(1);
    return it;
  endfunction

  task automatic test_logging_off();
    send_item(random_event());
    send_item(read_item(6'd5));
  endtask

  task automatic test_directed();
    set_logging(1'b1);
    send_item(read_item(6'd0));
    send_item(read_item(6'd3));
    // filtered by zero major
    send_item(event_item('1, '0, '1, '1, '1, PROBE_SINGLE));
    send_item(read_item(6'd4));
    send_item(event_item('1, '1, '1, '1, '1, PROBE_SINGLE));
    send_item(event_item('0, 12'd1, '0, '0, '0, PROBE_MULTI));
    send_item(event_item(22'h2aaaaa, 12'h555, 20'haaaaa, 64'h5555_5555_aaaa_aaaa,
                         63'h2aaa_aaaa_5555_5555, PROBE_NONE));
    send_item(event_item(22'h155555, 12'haaa, 20'h55555, 64'haaaa_aaaa_5555_5555,
                         63'h5555_5555_aaaa_aaaa, 2'd3));
    send_item(random_event());
    send_item(read_item(6'd0));
    send_item(read_item(6'd2));
    // oversized request clipped to what is held
    send_item(read_item(6'd63));
    send_item(read_item(6'd1));
  endtask

  task automatic test_overwrite();
    repeat (DEPTH + 1) send_item(random_event());
    send_item(read_item(6'd63));
    send_item(read_item(6'd1));
  endtask

  task automatic test_output_hold();
    wait_ring_idle();
    hold_len = HOLD_CYCLES;
    hold_seq = hold_seq + 1;
    repeat (6) send_item(random_event());
    send_item(read_item(6'd16));
    repeat (2) send_item(random_event());
    send_item(read_item(6'd63));
    repeat (2) send_item(random_event());
  endtask

  task automatic test_random_traffic(int unsigned n);
    repeat (n) send_item(random_item());
  endtask

  task automatic test_logging_phases();
    set_logging(1'b1);
    test_random_traffic(5);
    set_logging(1'b0);
    test_random_traffic(3);
    set_logging(1'b1);
    test_random_traffic(5);
  endtask

  task automatic test_back_to_back();
    wait_ring_idle();
    no_idle = 1'b1;
    test_random_traffic(16);
    send_item(read_item(6'd63));
    wait_ring_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_logging_off();
    test_directed();
    test_overwrite();
    test_output_hold();
    test_logging_phases();
    test_back_to_back();
    wait_ring_idle();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
design/trbo_pkg.sv
design/trbo_ctrl.sv
design/trbo_dp.sv
design/trace_ring_buffer_overwrite.sv
tb/tb_top.sv
